// ===== hdl/mm_pkg.sv =====
package mm_pkg;

    // Fixed field widths of the request and result items
    localparam int DATA_W     = 16;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 4;
    localparam int FRAC_BITS  = 8;
    localparam int MM_MAX_DIM = 8;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_COLS_B    = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_LOAD_A   = 2'd0,
        ACT_LOAD_B   = 2'd1,
        ACT_COMPUTE  = 2'd2,
        ACT_RESERVED = 2'd3
    } t_action;

    typedef struct packed {
        t_action                    action;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic signed [DATA_W-1:0]   value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]           res_row;
        logic [IDX_W-1:0]           res_col;
        logic signed [DATA_W-1:0]   res_value;
        logic                       last;
    } t_out_item;

    // Control handed from the sequencer to every cell
    typedef struct packed {
        logic rd_en;
        logic load_prod;
        logic acc_en;
        logic acc_first;
        logic shift_en;
    } t_mac_ctl;

endpackage

// ===== hdl/mm_cell.sv =====
module mm_cell import mm_pkg::*; #(
    parameter int IW    = 3,
    parameter int ACC_W = 2 * DATA_W + 3
) (
    input  logic                      i_clk,
    input  logic                      i_b_we,
    input  logic [IW-1:0]             i_b_waddr,
    input  logic signed [DATA_W-1:0]  i_b_wdata,
    input  logic [IW-1:0]             i_b_raddr,
    input  t_mac_ctl                  i_ctl,
    input  logic signed [DATA_W-1:0]  i_a_val,
    input  logic signed [ACC_W-1:0]   i_acc_next,
    output logic signed [ACC_W-1:0]   o_acc
);

    // One column of B lives in this cell
    logic signed [DATA_W-1:0]   r_b_mem [2**IW];
    logic signed [DATA_W-1:0]   r_b_q;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    // Store column entries, read one per step
    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_b_mem[i_b_waddr] <= i_b_wdata;
        end
        if (i_ctl.rd_en) begin
            r_b_q <= r_b_mem[i_b_raddr];
        end
    end

    // Multiply, then accumulate or shift toward the chain head
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= i_a_val * r_b_q;
        end
        if (i_ctl.acc_en) begin
            r_acc <= i_ctl.acc_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end else if (i_ctl.shift_en) begin
            r_acc <= i_acc_next;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hdl/matrix_multiply_core.sv =====
// Load requests (A or B element) are taken back to back while no compute runs.
// A compute request stalls the input until its run ends:
// per result row the cell chain walks inner_len steps of A and B, drains its
// three-stage read, multiply and accumulate pipeline, then shifts cols_b sums
// out through the head cell.
// Reset is synchronous, active low: sizes return to MAX_DIM, control clears,
// matrix contents are kept and are undefined until written.
module matrix_multiply_core import mm_pkg::*; #(
    parameter int MAX_DIM = MM_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int ACC_W = 2 * DATA_W + IW;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1 << (FRAC_BITS - 1));

    typedef enum logic [1:0] {S_IDLE, S_MAC, S_DRAIN, S_OUT} t_state;

    t_state                   r_state;
    logic [DIM_W-1:0]         r_rows, r_inner, r_cols;
    logic [IW-1:0]            r_row, r_k, r_col;
    logic                     r_v1, r_f1, r_v2, r_f2;
    logic                     r_out_valid;
    t_out_item                r_out_data;
    logic signed [DATA_W-1:0] r_a_mem [2**(2*IW)];
    logic signed [DATA_W-1:0] r_a_q;

    logic                     w_in_acc, w_in_range, w_cfg_wr, w_out_load;
    logic                     w_row_end, w_last_row, w_k_end;
    logic [MAX_DIM-1:0]       w_b_we;
    t_mac_ctl                 w_ctl;
    logic signed [ACC_W-1:0]  w_acc [MAX_DIM+1];
    logic signed [ACC_W-1:0]  w_sum, w_rnd;
    logic signed [DATA_W-1:0] w_sat;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_ROWS_A:    prdata = PDATA_W'(r_rows);
            REG_INNER_LEN: prdata = PDATA_W'(r_inner);
            REG_COLS_B:    prdata = PDATA_W'(r_cols);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_W'(MAX_DIM);
            r_inner <= DIM_W'(MAX_DIM);
            r_cols  <= DIM_W'(MAX_DIM);
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_ROWS_A:    r_rows  <= clamp_dim(pwdata[CFG_W-1:0]);
                REG_INNER_LEN: r_inner <= clamp_dim(pwdata[CFG_W-1:0]);
                REG_COLS_B:    r_cols  <= clamp_dim(pwdata[CFG_W-1:0]);
                default: ;
            endcase
        end
    end

    // Request handshake and load decode
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_in_range = ({1'b0, i_in_data.row} < (IDX_W + 1)'(MAX_DIM))
                     && ({1'b0, i_in_data.col} < (IDX_W + 1)'(MAX_DIM));

    // Store A, read one element per step
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_data.action == ACT_LOAD_A && w_in_range) begin
            r_a_mem[{i_in_data.row[IW-1:0], i_in_data.col[IW-1:0]}] <= i_in_data.value;
        end
        if (w_ctl.rd_en) begin
            r_a_q <= r_a_mem[{r_row, r_k}];
        end
    end

    always_comb begin
        for (int c = 0; c < MAX_DIM; c++) begin
            w_b_we[c] = w_in_acc && i_in_data.action == ACT_LOAD_B && w_in_range
                     && i_in_data.col[IW-1:0] == IW'(c);
        end
    end

    // Sequencer controls
    assign w_k_end    = (r_k == IW'(r_inner - 1'b1));
    assign w_row_end  = (r_col == IW'(r_cols - 1'b1));
    assign w_last_row = (r_row == IW'(r_rows - 1'b1));
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign w_ctl.rd_en     = (r_state == S_MAC);
    assign w_ctl.load_prod = r_v1;
    assign w_ctl.acc_en    = r_v2;
    assign w_ctl.acc_first = r_f2;
    assign w_ctl.shift_en  = w_out_load;

    // Chain of MAC cells, one per result column
    assign w_acc[MAX_DIM] = '0;

    for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
        mm_cell #(
            .IW    (IW),
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_b_we     (w_b_we[c]),
            .i_b_waddr  (i_in_data.row[IW-1:0]),
            .i_b_wdata  (i_in_data.value),
            .i_b_raddr  (r_k),
            .i_ctl      (w_ctl),
            .i_a_val    (r_a_q),
            .i_acc_next (w_acc[c+1]),
            .o_acc      (w_acc[c])
        );
    end

    // Round half up to Q8.8 and saturate the head cell's sum
    assign w_sum = w_acc[0] + RND_HALF;
    assign w_rnd = w_sum >>> FRAC_BITS;

    always_comb begin
        if (w_rnd > SAT_MAX) begin
            w_sat = SAT_MAX[DATA_W-1:0];
        end else if (w_rnd < SAT_MIN) begin
            w_sat = SAT_MIN[DATA_W-1:0];
        end else begin
            w_sat = w_rnd[DATA_W-1:0];
        end
    end

    // State, counters, pipeline flags and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_k         <= '0;
            r_col       <= '0;
            r_v1        <= 1'b0;
            r_f1        <= 1'b0;
            r_v2        <= 1'b0;
            r_f2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_MAC);
            r_f1 <= (r_state == S_MAC) && (r_k == '0);
            r_v2 <= r_v1;
            r_f2 <= r_f1;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in_data.action == ACT_COMPUTE) begin
                        r_state <= S_MAC;
                        r_row   <= '0;
                        r_k     <= '0;
                    end
                end
                S_MAC: begin
                    if (w_k_end) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_col   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_valid          <= 1'b1;
                        r_out_data.res_row   <= IDX_W'(r_row);
                        r_out_data.res_col   <= IDX_W'(r_col);
                        r_out_data.res_value <= w_sat;
                        r_out_data.last      <= w_row_end && w_last_row;
                        if (w_row_end) begin
                            r_col <= '0;
                            if (w_last_row) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_row   <= r_row + 1'b1;
                                r_state <= S_MAC;
                            end
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    // Sums leave the chain only after the multiply pipeline has drained
    a_drained_before_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (!r_v1 && !r_v2))
        else $error("cell chain shifted while products in flight");

    // Accumulation happens only while a row is being computed
    a_acc_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_MAC || r_state == S_DRAIN))
        else $error("accumulate outside a row computation");

    // The final result of a run returns the sequencer to idle
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_row_end && w_last_row) |=> (r_state == S_IDLE))
        else $error("run did not end after its last result");
`endif

endmodule
